// ----- hw/rtl/zcfp_pkg.sv -----
// Shared types and constants for the command frame parser.
`timescale 1ns / 1ps

package zcfp_pkg;

   localparam logic [7:0]  LEAD_BYTE        = 8'h5A;  // 'Z'
   localparam logic [7:0]  MODE_BYTE        = 8'h4D;  // 'M'
   localparam logic [7:0]  SUM_INVERT       = 8'hFF;
   localparam logic [15:0] TIMEOUT_RESET    = 16'd500;

   localparam logic        REQ_KIND_BYTE    = 1'b0;
   localparam logic        REQ_KIND_TICK    = 1'b1;

   typedef enum logic [1:0] {
      EV_PAYLOAD   = 2'd0,
      EV_GOOD      = 2'd1,
      EV_BAD_SUM   = 2'd2,
      EV_MODE_DONE = 2'd3
   } event_kind_type;

   typedef enum logic [7:0] {
      PH_IDLE      = 8'b0000_0001,
      PH_ONE_Z     = 8'b0000_0010,
      PH_WANT_OP   = 8'b0000_0100,
      PH_WANT_LEN  = 8'b0000_1000,
      PH_PAYLOAD   = 8'b0001_0000,
      PH_WANT_CHK  = 8'b0010_0000,
      PH_MODE      = 8'b0100_0000,
      PH_MODE_TERM = 8'b1000_0000
   } phase_type;

   typedef struct packed {
      event_kind_type event_kind;
      logic [7:0]     command_code;
      logic [7:0]     payload_byte;
      logic [7:0]     payload_index;
      logic [7:0]     frame_length;
   } result_type;

endpackage

// ----- hw/rtl/zcfp_parser.sv -----
// Frame parser state and per-item step logic.
`timescale 1ns / 1ps

module zcfp_parser import zcfp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        step_fire,
   input  logic        step_type,
   input  logic [7:0]  step_byte,
   input  logic [15:0] timeout,
   output logic        has_result,
   output result_type  result
);

   phase_type   phase_ff, phase_in, eff_phase;
   logic [7:0]  sum_ff, sum_in;
   logic [7:0]  opcode_ff, opcode_in;
   logic [7:0]  length_ff, length_in;
   logic [7:0]  seen_ff, seen_in;
   logic [7:0]  seen_inc;
   logic [15:0] ticks_ff, ticks_in;

   assign seen_inc = seen_ff + 8'd1;

   always_comb begin
      phase_in   = phase_ff;
      sum_in     = sum_ff;
      opcode_in  = opcode_ff;
      length_in  = length_ff;
      seen_in    = seen_ff;
      ticks_in   = ticks_ff;
      has_result = 1'b0;
      result     = '{EV_PAYLOAD, 8'd0, 8'd0, 8'd0, 8'd0};
      eff_phase  = phase_ff;

      if (step_type == REQ_KIND_TICK) begin
         if (ticks_ff >= timeout) begin
            phase_in = PH_IDLE;
            ticks_in = 16'd0;
         end else begin
            ticks_in = ticks_ff + 16'd1;
         end
      end else begin
         ticks_in = 16'd0;
         if (phase_ff == PH_ONE_Z && step_byte == LEAD_BYTE) begin
            phase_in = PH_WANT_OP;
         end else begin
            // single lead byte then something else: handle it as an idle byte
            if (phase_ff == PH_ONE_Z) begin
               eff_phase = PH_IDLE;
            end
            unique case (eff_phase)
               PH_WANT_OP: begin
                  if (step_byte != LEAD_BYTE) begin
                     opcode_in = step_byte;
                     sum_in    = step_byte;
                     phase_in  = PH_WANT_LEN;
                  end
               end
               PH_WANT_LEN: begin
                  length_in = step_byte;
                  sum_in    = sum_ff + step_byte;
                  seen_in   = 8'd0;
                  phase_in  = (step_byte != 8'd0) ? PH_PAYLOAD : PH_WANT_CHK;
               end
               PH_PAYLOAD: begin
                  sum_in     = sum_ff + step_byte;
                  seen_in    = seen_inc;
                  if (seen_inc == length_ff) begin
                     phase_in = PH_WANT_CHK;
                  end
                  has_result = 1'b1;
                  result     = '{EV_PAYLOAD, opcode_ff, step_byte, seen_ff, length_ff};
               end
               PH_WANT_CHK: begin
                  phase_in   = PH_IDLE;
                  has_result = 1'b1;
                  if ((sum_ff ^ SUM_INVERT) == step_byte) begin
                     result = '{EV_GOOD, opcode_ff, 8'd0, 8'd0, length_ff};
                  end else begin
                     result = '{EV_BAD_SUM, opcode_ff, 8'd0, 8'd0, length_ff};
                  end
               end
               PH_MODE: begin
                  phase_in = PH_MODE_TERM;
               end
               PH_MODE_TERM: begin
                  phase_in   = PH_IDLE;
                  has_result = 1'b1;
                  result     = '{EV_MODE_DONE, 8'd0, 8'd0, 8'd0, 8'd0};
               end
               default: begin
                  if (step_byte == LEAD_BYTE) begin
                     phase_in = PH_ONE_Z;
                  end else if (step_byte == MODE_BYTE) begin
                     phase_in = PH_MODE;
                  end else begin
                     phase_in = PH_IDLE;
                  end
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         sum_ff    <= 8'd0;
         opcode_ff <= 8'd0;
         length_ff <= 8'd0;
         seen_ff   <= 8'd0;
         ticks_ff  <= 16'd0;
      end else if (step_fire) begin
         phase_ff  <= phase_in;
         sum_ff    <= sum_in;
         opcode_ff <= opcode_in;
         length_ff <= length_in;
         seen_ff   <= seen_in;
         ticks_ff  <= ticks_in;
      end
   end

endmodule

// ----- hw/rtl/zz_command_frame_parser.sv -----
// Top level of the command frame parser: input register, parser, result register.
// An accepted item passes the input register and the parser step into the result register, which drives rsp_valid.
// Throughput: one byte or tick per cycle, set by the parser step, unless rsp_stall holds it.
// A result register stalled by rsp_stall holds the parser only for an item with a result; bubbles need no slot.
// Synchronous active-high reset: parser idle, all counters zero, timeout 500.
`timescale 1ns / 1ps

module zz_command_frame_parser import zcfp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_type,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_event_kind,
   output logic [7:0]  rsp_command_code,
   output logic [7:0]  rsp_payload_byte,
   output logic [7:0]  rsp_payload_index,
   output logic [7:0]  rsp_frame_length,
   input  logic        csr_write_enable,
   input  logic [15:0] csr_write_data
);

   logic [15:0] timeout_ff;
   logic        in_valid_ff;
   logic        in_type_ff;
   logic [7:0]  in_byte_ff;
   logic        out_valid_ff;
   result_type  out_data_ff;

   logic        has_result;
   result_type  step_result;
   logic        out_free;
   logic        step_fire;
   logic        req_xfer;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign step_fire = in_valid_ff && (out_free || !has_result);
   assign req_stall = in_valid_ff && !step_fire;
   assign req_xfer  = req_valid && !req_stall;

   zcfp_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .step_fire  (step_fire),
      .step_type  (in_type_ff),
      .step_byte  (in_byte_ff),
      .timeout    (timeout_ff),
      .has_result (has_result),
      .result     (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RESET;
      end else if (csr_write_enable) begin
         timeout_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_xfer) begin
         in_valid_ff <= 1'b1;
      end else if (step_fire) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_type_ff <= req_type;
         in_byte_ff <= req_rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (step_fire && has_result) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step_fire && has_result) begin
         out_data_ff <= step_result;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_event_kind    = out_data_ff.event_kind;
   assign rsp_command_code  = out_data_ff.command_code;
   assign rsp_payload_byte  = out_data_ff.payload_byte;
   assign rsp_payload_index = out_data_ff.payload_index;
   assign rsp_frame_length  = out_data_ff.frame_length;

endmodule
